FILE: rtl/abbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abbc_pkg
// Shared types, register indexes and constants for the clipped alpha blit.
// ----------------------------------------------------------------------------
package abbc_pkg;

   localparam int DEFAULT_MAX_DIM = 4096;

   localparam int REG_W      = 13;   // width of every configuration register
   localparam int CSR_IDX_W  = 3;
   localparam int SRC_W      = 32;
   localparam int DST_W      = 24;
   localparam int ADDR_W     = 24;
   localparam int PIX_W      = 24;
   localparam int CHAN_W     = 8;
   localparam int REQ_DATA_W = 56;   // 32 + 24, whole bytes
   localparam int RSP_DATA_W = 48;   // 24 + 24, whole bytes

   localparam logic [CHAN_W-1:0] ALPHA_MAX  = 8'hFF;
   localparam logic [15:0]       ROUND_BIAS = 16'd127;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEST_WIDTH    = 3'd0,
      REG_DEST_HEIGHT   = 3'd1,
      REG_DEST_PITCH    = 3'd2,
      REG_SPRITE_WIDTH  = 3'd3,
      REG_SPRITE_HEIGHT = 3'd4,
      REG_ORIGIN_X      = 3'd5,
      REG_ORIGIN_Y      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [REG_W-1:0] dest_width;
      logic [REG_W-1:0] dest_height;
      logic [REG_W-1:0] dest_pitch;
      logic [REG_W-1:0] sprite_width;
      logic [REG_W-1:0] sprite_height;
      logic [REG_W-1:0] origin_x;     // two's complement
      logic [REG_W-1:0] origin_y;     // two's complement
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      dest_width:    13'd640,
      dest_height:   13'd480,
      dest_pitch:    13'd640,
      sprite_width:  13'd64,
      sprite_height: 13'd64,
      origin_x:      13'd0,
      origin_y:      13'd0
   };

   // Placement of one pixel; row and col only meaningful when visible is set.
   typedef struct packed {
      logic             visible;
      logic             last;
      logic [REG_W-1:0] row;
      logic [REG_W-1:0] col;
   } pos_type;

endpackage

FILE: rtl/abbc_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abbc_walker
// Column / stored-row counters with vertical flip, origin offset and clip test.
// ----------------------------------------------------------------------------
module abbc_walker #(
   parameter int MAX_DIM = abbc_pkg::DEFAULT_MAX_DIM
) (
   input  logic              clock,
   input  logic              reset,
   input  abbc_pkg::cfg_type cfg,
   input  logic              advance,
   output abbc_pkg::pos_type pos
);
   import abbc_pkg::*;

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int EW = (DW > REG_W) ? DW : REG_W;
   localparam int SW = EW + 2;

   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [CW-1:0] row_cnt_ff, row_cnt_in;

   logic [EW-1:0] w_raw, h_raw, w_eff, h_eff;
   logic          end_row, end_sprite;
   logic signed [SW-1:0] col_s, row_s;

   assign w_raw = EW'(cfg.sprite_width);
   assign h_raw = EW'(cfg.sprite_height);

   always_comb begin
      if (w_raw == '0) begin
         w_eff = EW'(1);
      end else if (w_raw > EW'(MAX_DIM)) begin
         w_eff = EW'(MAX_DIM);
      end else begin
         w_eff = w_raw;
      end
      if (h_raw == '0) begin
         h_eff = EW'(1);
      end else if (h_raw > EW'(MAX_DIM)) begin
         h_eff = EW'(MAX_DIM);
      end else begin
         h_eff = h_raw;
      end
   end

   assign end_row    = EW'(col_cnt_ff) >= (w_eff - EW'(1));
   assign end_sprite = end_row && (EW'(row_cnt_ff) >= (h_eff - EW'(1)));

   // rows arrive bottom-up: destination row = origin_y + H - 1 - stored row
   assign col_s = SW'($signed(cfg.origin_x)) + $signed(SW'(col_cnt_ff));
   assign row_s = SW'($signed(cfg.origin_y)) + $signed(SW'(h_eff))
                  - $signed(SW'(1)) - $signed(SW'(row_cnt_ff));

   always_comb begin
      pos.visible = !col_s[SW-1] && !row_s[SW-1]
                    && (col_s < $signed(SW'(cfg.dest_width)))
                    && (row_s < $signed(SW'(cfg.dest_height)));
      pos.last    = end_sprite;
      pos.row     = row_s[REG_W-1:0];
      pos.col     = col_s[REG_W-1:0];
   end

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (advance) begin
         if (end_row) begin
            col_cnt_in = '0;
            row_cnt_in = end_sprite ? '0 : row_cnt_ff + CW'(1);
         end else begin
            col_cnt_in = col_cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

endmodule

FILE: rtl/abbc_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abbc_blend
// Per-channel alpha blend, rounded: floor(((255-a)*d + a*s + 127) / 255).
// ----------------------------------------------------------------------------
module abbc_blend (
   input  logic [abbc_pkg::SRC_W-1:0] src,
   input  logic [abbc_pkg::DST_W-1:0] dst,
   output logic [abbc_pkg::PIX_W-1:0] pix
);
   import abbc_pkg::*;

   logic [CHAN_W-1:0] alpha, inv_alpha;

   assign alpha     = src[31:24];
   assign inv_alpha = ALPHA_MAX - alpha;

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic [15:0] prod_s, prod_d, sum;
      logic [16:0] approx;

      assign prod_s = alpha * src[ch*CHAN_W +: CHAN_W];
      assign prod_d = inv_alpha * dst[ch*CHAN_W +: CHAN_W];
      assign sum    = prod_s + prod_d + ROUND_BIAS;   // at most 65152
      // exact x/255 for 16-bit x up to 65534: (x + (x >> 8) + 1) >> 8
      assign approx = 17'(sum) + 17'(sum[15:8]) + 17'd1;
      assign pix[ch*CHAN_W +: CHAN_W] = approx[15:8];
   end

endmodule

FILE: rtl/alpha_blend_blit_clipped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_blit_clipped
// Sprite blit stage: bottom-up row flip, origin placement, clipping, blend.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and returns one
// result per request; each result passes from the input register into the
// result register and so to the rsp port. The column/row counters in the
// walker step once per accepted request; blend and address multiply sit in
// the second stage.
// Clipped pixels come out with write_enable low and zero address and pixel;
// tlast marks the final pixel of the sprite. csr_ready is always high.
// Write configuration only while no requests are in flight.
module alpha_blend_blit_clipped #(
   parameter int MAX_DIM = abbc_pkg::DEFAULT_MAX_DIM
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: source_pixel [31:0], dest_pixel [55:32]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [abbc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: dest_address [23:0], blended_pixel [47:24]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [abbc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: write_enable [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [abbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [abbc_pkg::REG_W-1:0]          csr_data
);
   import abbc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   pos_type pos;

   logic              s1_valid_ff, s1_valid_in;
   logic [SRC_W-1:0]  s1_src_ff;
   logic [DST_W-1:0]  s1_dst_ff;
   pos_type           s1_pos_ff;

   logic              out_valid_ff, out_valid_in;
   logic              out_we_ff;
   logic              out_last_ff;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic [PIX_W-1:0]  out_pix_ff, out_pix_in;

   logic              s1_adv, s2_adv, req_accept;
   logic [PIX_W-1:0]  blend_pix;
   logic [2*REG_W-1:0] row_prod;
   logic [2*REG_W:0]   addr_full;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_DEST_WIDTH:    cfg_in.dest_width    = csr_data;
            REG_DEST_HEIGHT:   cfg_in.dest_height   = csr_data;
            REG_DEST_PITCH:    cfg_in.dest_pitch    = csr_data;
            REG_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_data;
            REG_SPRITE_HEIGHT: cfg_in.sprite_height = csr_data;
            REG_ORIGIN_X:      cfg_in.origin_x      = csr_data;
            REG_ORIGIN_Y:      cfg_in.origin_y      = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline flow
   assign s2_adv      = !out_valid_ff || rsp_tready;
   assign s1_adv      = !s1_valid_ff || s2_adv;
   assign req_tready  = s1_adv;
   assign req_accept  = req_tvalid && req_tready;
   assign s1_valid_in = s1_adv ? req_tvalid : s1_valid_ff;
   assign out_valid_in = s2_adv ? s1_valid_ff : out_valid_ff;

   abbc_walker #(
      .MAX_DIM (MAX_DIM)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (req_accept),
      .pos     (pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_src_ff <= req_tdata[SRC_W-1:0];
         s1_dst_ff <= req_tdata[SRC_W +: DST_W];
         s1_pos_ff <= pos;
      end
   end

   // blend and address
   abbc_blend u_blend (
      .src (s1_src_ff),
      .dst (s1_dst_ff),
      .pix (blend_pix)
   );

   assign row_prod  = s1_pos_ff.row * cfg_ff.dest_pitch;
   assign addr_full = (2*REG_W+1)'(row_prod) + (2*REG_W+1)'(s1_pos_ff.col);

   always_comb begin
      if (s1_pos_ff.visible) begin
         out_addr_in = addr_full[ADDR_W-1:0];
         out_pix_in  = blend_pix;
      end else begin
         out_addr_in = '0;
         out_pix_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_we_ff   <= s1_pos_ff.visible;
         out_last_ff <= s1_pos_ff.last;
         out_addr_ff <= out_addr_in;
         out_pix_ff  <= out_pix_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_pix_ff, out_addr_ff};
   assign rsp_tuser  = out_we_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: rtl/abbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abbc_checker
// Port-level checks for the clipped alpha blit, bound to the top level.
// ----------------------------------------------------------------------------
module abbc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [abbc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast,
   input logic                                csr_valid,
   input logic                                csr_ready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // clipped pixels carry zero address and pixel
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("clipped result not zero");

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // with the output slot free, a request is always taken
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && req_tvalid && $past(!rsp_tvalid) && !$past(req_tvalid)
      |-> req_tready)
      else $error("request refused with empty pipeline");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind alpha_blend_blit_clipped abbc_checker u_abbc_checker (.*);

FILE: bench/tb_alpha_blend_blit_clipped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_blend_blit_clipped
// Self-checking bench for the clipped alpha blit stage. Source/destination
// pixel requests go in with bursty valid, results come out under a stalling
// ready. Each accepted request is run through a local model of the row flip,
// clipping, address and blend, and results are compared in order.
// ----------------------------------------------------------------------------
module tb_alpha_blend_blit_clipped;
   import abbc_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 1550;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;   // no register here

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  pix;
      logic              last;
   } pixel_out_type;

   typedef struct {
      bit                   is_reg;
      logic [CSR_IDX_W-1:0] idx;
      logic [REG_W-1:0]     val;
      logic [SRC_W-1:0]     src;
      logic [DST_W-1:0]     dst;
      bit                   known;
      pixel_out_type        want;
   } step_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;    // source_pixel [31:0], dest_pixel [55:32]
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;    // dest_address [23:0], blended_pixel [47:24]
   logic                    rsp_tuser;    // write_enable [0]
   logic                    rsp_tlast;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [REG_W-1:0]        csr_data;

   // local copy of the block's registers and walk counters
   cfg_type                 shadow = CFG_RESET;
   logic [11:0]             col_cnt = '0;
   logic [11:0]             row_cnt = '0;

   pixel_out_type           pixels_due[$];
   step_type                directed_steps[$];
   int                      errors = 0;
   int                      cycles = 0;
   int                      burst_left = 0;
   bit                      offering = 0;
   bit                      poking = 0;
   bit                      squeeze_req = 0;

   alpha_blend_blit_clipped uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model
   function automatic int eff_dim(input logic [REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DEFAULT_MAX_DIM) return DEFAULT_MAX_DIM;
      return int'(v);
   endfunction

   function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] s,
                                                     input logic [CHAN_W-1:0] d);
      int sum;
      sum = (int'(ALPHA_MAX) - int'(a)) * int'(d) + int'(a) * int'(s) + int'(ROUND_BIAS);
      return CHAN_W'(sum / int'(ALPHA_MAX));
   endfunction

   // Places and blends one sprite pixel, then steps the walk counters.
   function automatic pixel_out_type place_pixel(input logic [SRC_W-1:0] src,
                                                 input logic [DST_W-1:0] dst);
      pixel_out_type r;
      int w, h, col, row;
      bit end_row, end_sprite;
      logic [CHAN_W-1:0] a;
      w = eff_dim(shadow.sprite_width);
      h = eff_dim(shadow.sprite_height);
      col = int'($signed(shadow.origin_x)) + int'(col_cnt);
      // stored rows arrive bottom-up; flip to screen rows
      row = int'($signed(shadow.origin_y)) + h - 1 - int'(row_cnt);
      end_row = int'(col_cnt) >= w - 1;
      end_sprite = end_row && int'(row_cnt) >= h - 1;
      r = '0;
      r.last = end_sprite;
      if (col >= 0 && row >= 0 && col < int'(shadow.dest_width) &&
          row < int'(shadow.dest_height)) begin
         a = src[31:24];
         r.we = 1'b1;
         r.addr = ADDR_W'(row * int'(shadow.dest_pitch) + col);
         r.pix = {mix_channel(a, src[23:16], dst[23:16]),
                  mix_channel(a, src[15:8], dst[15:8]),
                  mix_channel(a, src[7:0], dst[7:0])};
      end
      if (end_row) begin
         col_cnt = '0;
         row_cnt = end_sprite ? '0 : row_cnt + 1'b1;
      end else begin
         col_cnt = col_cnt + 1'b1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic hold_requests();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 0;
      end
   endtask

   // stop offering and let every outstanding request drain
   task automatic settle();
      hold_requests();
      while (pixels_due.size() != 0) @(negedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need no re-raise
   task automatic poke_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      poking = 1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_DEST_WIDTH:    shadow.dest_width    = val;
         REG_DEST_HEIGHT:   shadow.dest_height   = val;
         REG_DEST_PITCH:    shadow.dest_pitch    = val;
         REG_SPRITE_WIDTH:  shadow.sprite_width  = val;
         REG_SPRITE_HEIGHT: shadow.sprite_height = val;
         REG_ORIGIN_X:      shadow.origin_x      = val;
         REG_ORIGIN_Y:      shadow.origin_y      = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic push_pixel(input logic [SRC_W-1:0] src, input logic [DST_W-1:0] dst,
                             input bit known, input pixel_out_type typed);
      pixel_out_type guess;
      if (poking) begin
         csr_valid <= 1'b0;
         poking = 0;
      end
      if (burst_left == 0) begin
         hold_requests();
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dst, src};
      offering = 1;
      do @(posedge clock); while (!req_tready);
      guess = place_pixel(src, dst);
      pixels_due.push_back(known ? typed : guess);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic plan_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      step_type s;
      s = '{default: '0};
      s.is_reg = 1;
      s.idx = idx;
      s.val = val;
      directed_steps.push_back(s);
   endtask

   task automatic plan_pixel(input logic [SRC_W-1:0] src, input logic [DST_W-1:0] dst);
      step_type s;
      s = '{default: '0};
      s.src = src;
      s.dst = dst;
      directed_steps.push_back(s);
   endtask

   task automatic plan_known(input logic [SRC_W-1:0] src, input logic [DST_W-1:0] dst,
                             input logic we, input logic [ADDR_W-1:0] addr,
                             input logic [PIX_W-1:0] pix, input logic last);
      step_type s;
      s = '{default: '0};
      s.src = src;
      s.dst = dst;
      s.known = 1;
      s.want = '{we: we, addr: addr, pix: pix, last: last};
      directed_steps.push_back(s);
   endtask

   function automatic logic [REG_W-1:0] rand_span();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return REG_W'($urandom_range(4096, 8191));
         default: return REG_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [REG_W-1:0] rand_extent();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return REG_W'($urandom);
         2:       return '1;
         default: return REG_W'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [REG_W-1:0] rand_origin();
      if ($urandom_range(0, 7) == 0) return REG_W'($urandom);
      return REG_W'(int'($urandom_range(0, 12)) - 4);
   endfunction

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      step_type s;
      logic [SRC_W-1:0] src;
      logic [DST_W-1:0] dst;
      int n, area, total, k;
      bit first;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset geometry: 64x64 sprite at the origin of a 640-wide surface
      plan_known(32'hFF123456, 24'hABCDEF, 1'b1, 24'd40320, 24'h123456, 1'b0);
      plan_known(32'h00FFFFFF, 24'h000000, 1'b1, 24'd40321, 24'h000000, 1'b0);
      plan_pixel(32'h80FF00FF, 24'h00FF00);
      // zero sprite size clamps to 1; column counter is already past the end
      plan_reg(REG_SPRITE_WIDTH, '0);
      plan_reg(REG_SPRITE_HEIGHT, '0);
      plan_pixel(32'h7F010203, 24'hFFFFFF);
      plan_pixel(32'h01FEFDFC, 24'h808080);
      // register extremes, oversize sprite clamps to the max dimension
      plan_reg(REG_DEST_WIDTH, '1);
      plan_reg(REG_DEST_HEIGHT, '1);
      plan_reg(REG_DEST_PITCH, '1);
      plan_reg(REG_SPRITE_WIDTH, '1);
      plan_reg(REG_SPRITE_HEIGHT, 13'd4096);
      plan_reg(REG_ORIGIN_X, 13'h1000);
      plan_reg(REG_ORIGIN_Y, 13'd4095);
      plan_known(32'hFFFFFFFF, 24'hFFFFFF, 1'b0, '0, '0, 1'b0);
      plan_reg(REG_ORIGIN_X, 13'd4095);
      plan_pixel(32'hFE00FF00, 24'h0000FF);   // address wraps at 24 bits
      plan_reg(REG_DEST_WIDTH, '0);
      plan_known(32'hFFAA55AA, 24'h123456, 1'b0, '0, '0, 1'b0);
      plan_reg(REG_UNUSED, '1);
      plan_reg(REG_DEST_WIDTH, 13'd16);
      plan_reg(REG_DEST_HEIGHT, 13'd8);
      plan_reg(REG_DEST_PITCH, 13'd20);
      plan_reg(REG_SPRITE_WIDTH, 13'd3);
      plan_reg(REG_SPRITE_HEIGHT, 13'd2);
      plan_reg(REG_ORIGIN_X, '1);
      plan_reg(REG_ORIGIN_Y, '1);
      plan_pixel(32'h00000000, 24'hFFFFFF);
      plan_pixel(32'hFFFFFFFF, 24'h000000);
      plan_pixel(32'h80808080, 24'h7F7F7F);
      plan_pixel(32'h01FF00FF, 24'h00FF00);
      plan_pixel(32'hFE0000FF, 24'hFFFF00);
      plan_pixel(32'h40C0C0C0, 24'h204060);
      plan_pixel(32'hC0102030, 24'hF0E0D0);
      plan_pixel(32'h7FFFFFFF, 24'hFFFFFF);

      while (directed_steps.size() != 0) begin
         s = directed_steps.pop_front();
         if (s.is_reg) begin
            settle();
            poke_reg(s.idx, s.val);
         end else begin
            push_pixel(s.src, s.dst, s.known, s.want);
         end
      end

      // random geometry per pass; most passes walk whole sprites, some stop
      // mid-sprite so the next pass starts with counters out of range
      total = 0;
      first = 1;
      while (total < RANDOM_ITEMS) begin
         settle();
         poke_reg(REG_DEST_WIDTH, rand_extent());
         poke_reg(REG_DEST_HEIGHT, rand_extent());
         poke_reg(REG_DEST_PITCH, ($urandom_range(0, 4) == 0) ? REG_W'($urandom)
                                                            : REG_W'($urandom_range(1, 16)));
         poke_reg(REG_SPRITE_WIDTH, rand_span());
         poke_reg(REG_SPRITE_HEIGHT, rand_span());
         poke_reg(REG_ORIGIN_X, rand_origin());
         poke_reg(REG_ORIGIN_Y, rand_origin());
         if ($urandom_range(0, 7) == 0) poke_reg(REG_UNUSED, REG_W'($urandom));
         area = eff_dim(shadow.sprite_width) * eff_dim(shadow.sprite_height);
         if (first) begin
            n = 200;
            squeeze_req = 1;   // receiver backs off as this pass begins
            first = 0;
         end else if (area <= 64) begin
            n = area * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(0, area - 1);
         end else begin
            n = $urandom_range(1, 40);
         end
         repeat (n) begin
            src = $urandom;
            case ($urandom_range(0, 3))
               0: src[31:24] = '0;
               1: src[31:24] = ALPHA_MAX;
               default: ;
            endcase
            dst = DST_W'($urandom);
            push_pixel(src, dst, 1'b0, '0);
         end
         total += n;
      end

      hold_requests();
      for (k = 0; k < 5000 && pixels_due.size() != 0; k++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pixels_due.size() != 0) begin
         $error("%0d results never arrived", pixels_due.size());
         errors++;
      end
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- sink
   initial begin : receiver
      int mode, span, i;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         mode = $urandom_range(0, 9);
         span = $urandom_range(8, 60);
         if (squeeze_req) begin
            squeeze_req = 0;
            mode = 9;
            span = 150;
         end
         for (i = 0; i < span && !squeeze_req; i++) begin
            if (mode < 4)
               rsp_tready <= 1'b1;
            else if (mode < 9)
               rsp_tready <= 1'($urandom_range(0, 1));
            else
               rsp_tready <= 1'b0;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : result_check
      pixel_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixels_due.size() == 0) begin
            $error("result with no request pending");
            errors++;
         end else begin
            want = pixels_due.pop_front();
            if (rsp_tuser !== want.we) begin
               $error("write_enable: expected %0d, got %0d", want.we, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[23:0] !== want.addr) begin
               $error("dest_address: expected %0h, got %0h", want.addr, rsp_tdata[23:0]);
               errors++;
            end
            if (rsp_tdata[47:24] !== want.pix) begin
               $error("blended_pixel: expected %0h, got %0h", want.pix, rsp_tdata[47:24]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule

FILE: alpha_blend_blit_clipped.f
rtl/abbc_pkg.sv
rtl/abbc_walker.sv
rtl/abbc_blend.sv
rtl/alpha_blend_blit_clipped.sv
rtl/abbc_checker.sv
bench/tb_alpha_blend_blit_clipped.sv
